/* rtl/gtlpe_pkg.sv */
// ---------------------------------------------------------------------------
// gtlpe_pkg: shared types and constants of the glyph text layout pixel emitter
// Holds coordinate widths, the configuration register map, the saturating
// coordinate adder and the glyph placement record passed between modules.
// ---------------------------------------------------------------------------
package gtlpe_pkg;

    localparam int COORD_W    = 11;
    localparam int FS_W       = 6;
    localparam int CODE_W     = 16;
    localparam int COLOUR_W   = 16;
    localparam int ROW_W      = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 11;

    localparam logic [CODE_W-1:0]  HALF_WIDTH_LIMIT = CODE_W'(127);
    localparam logic [FS_W-1:0]    ROW_COUNT_MAX    = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FONT_SIZE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH = CFG_IDX_W'(1);

    localparam logic [FS_W-1:0]    FONT_SIZE_RESET    = FS_W'(16);
    localparam logic [COORD_W-1:0] SCREEN_WIDTH_RESET = COORD_W'(160);

    // Origin of the glyph a row belongs to, its row number and its colour.
    typedef struct packed {
        logic [COORD_W-1:0]  glyph_x;
        logic [COORD_W-1:0]  glyph_y;
        logic [FS_W-1:0]     row_count;
        logic [COLOUR_W-1:0] colour;
    } glyph_place_t;

    // Coordinate add that clips at the largest coordinate.
    function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
        logic [COORD_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[COORD_W] ? '1 : sum[COORD_W-1:0];
    endfunction

endpackage

/* rtl/gtlpe_row_if.sv */
// ---------------------------------------------------------------------------
// gtlpe_row_if: glyph row input channel
// Carries one glyph bitmap row with its string and glyph markers per word.
// ---------------------------------------------------------------------------
interface gtlpe_row_if;
    import gtlpe_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 string_start;
    logic [COORD_W-1:0]   start_x;
    logic [COORD_W-1:0]   start_y;
    logic                 glyph_start;
    logic [CODE_W-1:0]    code_point;
    logic [ROW_W-1:0]     row_bits;
    logic [COLOUR_W-1:0]  pixel_colour;

    modport source (output valid, string_start, start_x, start_y, glyph_start,
                    code_point, row_bits, pixel_colour, input ready);
    modport sink (input valid, string_start, start_x, start_y, glyph_start,
                  code_point, row_bits, pixel_colour, output ready);
endinterface

/* rtl/gtlpe_pixel_if.sv */
// ---------------------------------------------------------------------------
// gtlpe_pixel_if: pixel output channel
// Carries one pixel write, coordinate and colour, per word.
// ---------------------------------------------------------------------------
interface gtlpe_pixel_if;
    import gtlpe_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [COORD_W-1:0]   pixel_x;
    logic [COORD_W-1:0]   pixel_y;
    logic [COLOUR_W-1:0]  out_colour;
    logic                 last_pixel;

    modport source (output valid, pixel_x, pixel_y, out_colour, last_pixel,
                    input ready);
    modport sink (input valid, pixel_x, pixel_y, out_colour, last_pixel,
                  output ready);
endinterface

/* rtl/gtlpe_cfg_if.sv */
// ---------------------------------------------------------------------------
// gtlpe_cfg_if: configuration write channel
// Carries a register index and write data per word.
// ---------------------------------------------------------------------------
interface gtlpe_cfg_if;
    import gtlpe_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/gtlpe_layout.sv */
// ---------------------------------------------------------------------------
// gtlpe_layout: cursor and glyph placement
// Holds the configuration and the text cursor, places glyphs with line wrap
// and turns an incoming row into a left-to-right column mask.
// ---------------------------------------------------------------------------
module gtlpe_layout
    import gtlpe_pkg::*;
#(
    parameter int MASK_W = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  row_take,
    input  logic                  string_start,
    input  logic [COORD_W-1:0]    start_x,
    input  logic [COORD_W-1:0]    start_y,
    input  logic                  glyph_start,
    input  logic [CODE_W-1:0]     code_point,
    input  logic [ROW_W-1:0]      row_bits,
    input  logic [COLOUR_W-1:0]   pixel_colour,
    output glyph_place_t          place,
    output logic [MASK_W-1:0]     col_mask
);

    logic [FS_W-1:0]    font_size_reg;
    logic [COORD_W-1:0] screen_width_reg;
    logic [COORD_W-1:0] cursor_x_reg, cursor_x_next;
    logic [COORD_W-1:0] cursor_y_reg, cursor_y_next;
    logic [COORD_W-1:0] glyph_x_reg, glyph_x_next;
    logic [COORD_W-1:0] glyph_y_reg, glyph_y_next;
    logic [FS_W-1:0]    row_count_reg, row_count_next;

    logic [FS_W-1:0]    fs;
    logic [FS_W-1:0]    adv;
    logic [FS_W-1:0]    shamt;
    logic [COORD_W-1:0] cx0, cy0, cx1, cy1;
    logic [COORD_W:0]   reach;
    logic               wrap;
    logic [FS_W-1:0]    rc_cur;
    logic [MASK_W-1:0]  rev_bits;

    always_comb
    begin
        // Effective size never exceeds the mask width.
        fs    = (font_size_reg > FS_W'(MASK_W)) ? FS_W'(MASK_W) : font_size_reg;
        adv   = (code_point <= HALF_WIDTH_LIMIT) ? (fs >> 1) : fs;
        cx0   = string_start ? start_x : cursor_x_reg;
        cy0   = string_start ? start_y : cursor_y_reg;
        reach = {1'b0, cx0} + (COORD_W+1)'(adv);
        wrap  = reach > {1'b0, screen_width_reg};
        cx1   = wrap ? '0 : cx0;
        cy1   = wrap ? sat_add(cy0, COORD_W'(fs)) : cy0;

        if (glyph_start)
        begin
            glyph_x_next  = cx1;
            glyph_y_next  = cy1;
            cursor_x_next = sat_add(cx1, COORD_W'(adv));
            cursor_y_next = cy1;
            rc_cur        = '0;
        end
        else
        begin
            glyph_x_next  = glyph_x_reg;
            glyph_y_next  = glyph_y_reg;
            cursor_x_next = cx0;
            cursor_y_next = cy0;
            rc_cur        = row_count_reg;
        end
        row_count_next = (rc_cur == ROW_COUNT_MAX) ? rc_cur : rc_cur + FS_W'(1);

        // Bit fs-1 of the row is column 0: reverse, then shift down.
        for (int i = 0; i < MASK_W; i++)
        begin
            rev_bits[i] = row_bits[MASK_W-1-i];
        end
        shamt    = FS_W'(MASK_W) - fs;
        col_mask = (rc_cur < fs) ? (rev_bits >> shamt) : '0;

        place.glyph_x   = glyph_x_next;
        place.glyph_y   = glyph_y_next;
        place.row_count = rc_cur;
        place.colour    = pixel_colour;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_size_reg    <= FONT_SIZE_RESET;
            screen_width_reg <= SCREEN_WIDTH_RESET;
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
            glyph_x_reg      <= '0;
            glyph_y_reg      <= '0;
            row_count_reg    <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_FONT_SIZE)
            begin
                font_size_reg <= cfg_data[FS_W-1:0];
            end
            if (cfg_we && cfg_index == CFG_SCREEN_WIDTH)
            begin
                screen_width_reg <= cfg_data[COORD_W-1:0];
            end
            if (row_take)
            begin
                cursor_x_reg  <= cursor_x_next;
                cursor_y_reg  <= cursor_y_next;
                glyph_x_reg   <= glyph_x_next;
                glyph_y_reg   <= glyph_y_next;
                row_count_reg <= row_count_next;
            end
        end
    end

endmodule

/* rtl/gtlpe_emitter.sv */
// ---------------------------------------------------------------------------
// gtlpe_emitter: row register and pixel output register
// Holds the column mask of one row and sends one pixel per set column,
// leftmost first, through a registered output.
// ---------------------------------------------------------------------------
module gtlpe_emitter
    import gtlpe_pkg::*;
#(
    parameter int MASK_W = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 row_take,
    input  glyph_place_t         place,
    input  logic [MASK_W-1:0]    col_mask,
    output logic                 row_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [COORD_W-1:0]   pixel_x,
    output logic [COORD_W-1:0]   pixel_y,
    output logic [COLOUR_W-1:0]  out_colour,
    output logic                 last_pixel
);

    localparam int IDX_W = $clog2(MASK_W);

    logic [MASK_W-1:0]   mask_reg, mask_next;
    glyph_place_t        place_reg;
    logic                out_valid_reg;
    logic [COORD_W-1:0]  pixel_x_reg, pixel_y_reg;
    logic [COLOUR_W-1:0] colour_reg;
    logic                last_reg;

    logic                slot_free;
    logic                emit_go;
    logic [IDX_W-1:0]    col_idx;
    logic [MASK_W-1:0]   mask_rest;

    always_comb
    begin
        col_idx = '0;
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                col_idx = IDX_W'(i);
            end
        end
        mask_rest = mask_reg & (mask_reg - MASK_W'(1));
        slot_free = !out_valid_reg || out_ready;
        emit_go   = (mask_reg != '0) && slot_free;
        row_ready = (mask_reg == '0) || (emit_go && mask_rest == '0);
        if (row_take)
        begin
            mask_next = col_mask;
        end
        else if (emit_go)
        begin
            mask_next = mask_rest;
        end
        else
        begin
            mask_next = mask_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_take)
        begin
            place_reg <= place;
        end
        if (emit_go)
        begin
            pixel_x_reg <= sat_add(place_reg.glyph_x, COORD_W'(col_idx));
            pixel_y_reg <= sat_add(place_reg.glyph_y, COORD_W'(place_reg.row_count));
            colour_reg  <= place_reg.colour;
            last_reg    <= (mask_rest == '0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_x    = pixel_x_reg;
    assign pixel_y    = pixel_y_reg;
    assign out_colour = colour_reg;
    assign last_pixel = last_reg;

endmodule

/* rtl/glyph_text_layout_pixel_emitter_unit.sv */
// ---------------------------------------------------------------------------
// glyph_text_layout_pixel_emitter_unit: bitmap font text line renderer
// Places glyph rows on a text line and emits one pixel write per set bit.
// ---------------------------------------------------------------------------
// Each word on row_in is one glyph row. The single pixel output register sends
// one pixel per cycle while the pixel output is not stalled. A new row is taken
// in the same cycle that the last pixel of the previous row moves to the output
// register, so rows follow each other with no gap. Glyph placement (string
// start, line wrap, half-width advance for code points up to 127) happens
// combinationally as a row word is taken. Configuration writes on cfg are
// always taken at once and must only be made while no row is in flight.
// Coordinates clip at 2047.
module glyph_text_layout_pixel_emitter_unit
    import gtlpe_pkg::*;
#(
    parameter int MAX_FONT_SIZE = 32
)
(
    input  logic           clk,
    input  logic           rst_n,
    gtlpe_row_if.sink      row_in,
    gtlpe_pixel_if.source  pixel_out,
    gtlpe_cfg_if.sink      cfg
);

    // The column mask is as wide as the largest usable glyph.
    localparam int MASK_W = (MAX_FONT_SIZE < ROW_W) ? MAX_FONT_SIZE : ROW_W;

    glyph_place_t       place;
    logic [MASK_W-1:0]  col_mask;
    logic               row_ready;
    logic               row_take;
    logic               cfg_we;

    assign cfg.ready    = 1'b1;
    assign cfg_we       = cfg.valid;
    assign row_in.ready = row_ready;
    assign row_take     = row_in.valid && row_ready;

    // Cursor, configuration and row-to-mask conversion.
    gtlpe_layout #(
        .MASK_W (MASK_W)
    ) u_layout (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .row_take     (row_take),
        .string_start (row_in.string_start),
        .start_x      (row_in.start_x),
        .start_y      (row_in.start_y),
        .glyph_start  (row_in.glyph_start),
        .code_point   (row_in.code_point),
        .row_bits     (row_in.row_bits),
        .pixel_colour (row_in.pixel_colour),
        .place        (place),
        .col_mask     (col_mask)
    );

    // Row register, column walk and pixel output register.
    gtlpe_emitter #(
        .MASK_W (MASK_W)
    ) u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .row_take   (row_take),
        .place      (place),
        .col_mask   (col_mask),
        .row_ready  (row_ready),
        .out_valid  (pixel_out.valid),
        .out_ready  (pixel_out.ready),
        .pixel_x    (pixel_out.pixel_x),
        .pixel_y    (pixel_out.pixel_y),
        .out_colour (pixel_out.out_colour),
        .last_pixel (pixel_out.last_pixel)
    );

endmodule

/* rtl/gtlpe_checker.sv */
// ---------------------------------------------------------------------------
// gtlpe_checker: port-level checks of the text renderer
// Watches the row and pixel channels and is bound to the top level.
// ---------------------------------------------------------------------------
module gtlpe_checker
    import gtlpe_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [COORD_W-1:0] pixel_x,
    input logic [COORD_W-1:0] pixel_y,
    input logic               last_pixel
);

    // A pixel that is not taken stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("pixel dropped while stalled");

    // A stalled pixel keeps its coordinates.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pixel_x) && $stable(pixel_y))
        else $error("stalled pixel changed");

    // Pixels of one row follow each other without a gap.
    a_row_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_pixel |=> out_valid)
        else $error("gap inside a row");

    // No new row while pixels of the current row are still held back.
    a_no_take_mid_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && !last_pixel |-> !in_ready)
        else $error("row taken while current row is stalled");

endmodule

bind glyph_text_layout_pixel_emitter_unit gtlpe_checker u_gtlpe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (row_in.ready),
    .out_valid  (pixel_out.valid),
    .out_ready  (pixel_out.ready),
    .pixel_x    (pixel_out.pixel_x),
    .pixel_y    (pixel_out.pixel_y),
    .last_pixel (pixel_out.last_pixel)
);

/* verif/glyph_text_layout_pixel_emitter_unit_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// glyph_text_layout_pixel_emitter_unit_test: self-checking bench of the text renderer
// Streams glyph rows into the block and predicts every pixel write from its own
// cursor and glyph placement model. Pixel words are checked field by field in
// order. The run covers directed corner rows, then random text runs under several
// font and screen settings and with random idle and stall patterns.
// ---------------------------------------------------------------------------
module glyph_text_layout_pixel_emitter_unit_test;
    import gtlpe_pkg::*;

    // Same glyph size limit as the instance below.
    localparam int GLYPH_LIMIT = 32;
    localparam int COORD_TOP   = 2047;

    typedef struct packed {
        logic                string_start;
        logic [COORD_W-1:0]  start_x;
        logic [COORD_W-1:0]  start_y;
        logic                glyph_start;
        logic [CODE_W-1:0]   code_point;
        logic [ROW_W-1:0]    row_bits;
        logic [COLOUR_W-1:0] pixel_colour;
    } row_word_t;

    typedef struct packed {
        logic [COORD_W-1:0]  pixel_x;
        logic [COORD_W-1:0]  pixel_y;
        logic [COLOUR_W-1:0] out_colour;
        logic                last_pixel;
    } pixel_word_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_word_t;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic clk;
    logic rst_n;

    gtlpe_row_if   row_ch();
    gtlpe_pixel_if pix_ch();
    gtlpe_cfg_if   cfg_ch();

    glyph_text_layout_pixel_emitter_unit #(
        .MAX_FONT_SIZE(GLYPH_LIMIT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_in    (row_ch),
        .pixel_out (pix_ch),
        .cfg       (cfg_ch)
    );

    // Rows and register writes waiting to be sent, and the pixel words that the
    // block still owes us, oldest first.
    row_word_t   pending_rows[$];
    cfg_word_t   pending_writes[$];
    pixel_word_t expected_pixels[$];

    // Model state: register copies, the running cursor, the current glyph
    // origin and the number of rows seen since the last glyph start.
    int font_reg;
    int width_reg;
    int caret_x;
    int caret_y;
    int origin_x;
    int origin_y;
    int rows_seen;

    // The word currently offered on each input channel.
    row_word_t offered_row;
    cfg_word_t offered_write;

    idle_mode_t idle_mode = IDLE_NONE;
    int errors = 0;
    int items_queued = 0;

    // Settings the stimulus generator shapes its text runs around.
    int gen_fs = 16;
    int gen_sw = 160;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs or drops pixels.
    initial
    begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int clip_coord(input int v);
        return (v > COORD_TOP) ? COORD_TOP : v;
    endfunction

    // Decides whether one side holds off this cycle under the current idle mode.
    function automatic bit roll_idle(input bit receiver_side);
        int pct;
        case (idle_mode)
            IDLE_SENDER:   pct = receiver_side ? 0 : 71;
            IDLE_RECEIVER: pct = receiver_side ? 71 : 0;
            IDLE_BOTH:     pct = 15;
            default:       pct = 0;
        endcase
        return $urandom_range(99, 0) < pct;
    endfunction

    // Works out the pixel words that one accepted row causes and updates the
    // cursor. The glyph size is clamped to the instance limit and to 32; the
    // same clamped size drives the advance, the wrap and the line step.
    function automatic void render_row(input row_word_t w);
        int fs;
        int adv;
        int line_y;
        int last_col;
        int col;
        pixel_word_t px;
        fs = font_reg;
        if (fs > GLYPH_LIMIT)
            fs = GLYPH_LIMIT;
        if (fs > 32)
            fs = 32;
        if (w.string_start)
        begin
            caret_x = w.start_x;
            caret_y = w.start_y;
        end
        if (w.glyph_start)
        begin
            adv = (w.code_point <= HALF_WIDTH_LIMIT) ? fs / 2 : fs;
            // Wrap before placing when the glyph would run past the screen edge.
            if (caret_x + adv > width_reg)
            begin
                caret_x = 0;
                caret_y = clip_coord(caret_y + fs);
            end
            origin_x = caret_x;
            origin_y = caret_y;
            caret_x = clip_coord(caret_x + adv);
            rows_seen = 0;
        end
        if (rows_seen < fs)
        begin
            line_y = clip_coord(origin_y + rows_seen);
            // Column 0 sits at bit fs-1; find the rightmost set column first so
            // that its word can carry the end-of-row flag.
            last_col = -1;
            for (col = 0; col < fs; col++)
                if (w.row_bits[fs - 1 - col])
                    last_col = col;
            for (col = 0; col < fs; col++)
            begin
                if (w.row_bits[fs - 1 - col])
                begin
                    px.pixel_x    = COORD_W'(clip_coord(origin_x + col));
                    px.pixel_y    = COORD_W'(line_y);
                    px.out_colour = w.pixel_colour;
                    px.last_pixel = (col == last_col);
                    expected_pixels.push_back(px);
                end
            end
        end
        if (rows_seen < 63)
            rows_seen++;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            errors++;
            if (errors <= 50)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                         want, got);
        end
    endtask

    // Row sender. A row is predicted at the edge where it is accepted; the next
    // row is put up in the same step, so valid never drops between back to back
    // rows unless the sender decides to idle.
    always @(posedge clk or negedge rst_n)
    begin : row_driver
        logic take_next;
        if (!rst_n)
        begin
            row_ch.valid        <= 1'b0;
            row_ch.string_start <= 1'b0;
            row_ch.start_x      <= '0;
            row_ch.start_y      <= '0;
            row_ch.glyph_start  <= 1'b0;
            row_ch.code_point   <= '0;
            row_ch.row_bits     <= '0;
            row_ch.pixel_colour <= '0;
            offered_row = '0;
            caret_x   = 0;
            caret_y   = 0;
            origin_x  = 0;
            origin_y  = 0;
            rows_seen = 0;
        end
        else
        begin
            if (row_ch.valid && row_ch.ready)
                render_row(offered_row);
            take_next = (!row_ch.valid || row_ch.ready) && pending_rows.size() != 0
                        && !roll_idle(1'b0);
            if (take_next)
            begin
                offered_row = pending_rows.pop_front();
                row_ch.valid        <= 1'b1;
                row_ch.string_start <= offered_row.string_start;
                row_ch.start_x      <= offered_row.start_x;
                row_ch.start_y      <= offered_row.start_y;
                row_ch.glyph_start  <= offered_row.glyph_start;
                row_ch.code_point   <= offered_row.code_point;
                row_ch.row_bits     <= offered_row.row_bits;
                row_ch.pixel_colour <= offered_row.pixel_colour;
            end
            else if (!row_ch.valid || row_ch.ready)
            begin
                row_ch.valid <= 1'b0;
            end
        end
    end

    // Register writer. The model copy of a register changes at the edge where
    // the write is accepted.
    always @(posedge clk or negedge rst_n)
    begin : cfg_driver
        if (!rst_n)
        begin
            cfg_ch.valid <= 1'b0;
            cfg_ch.index <= '0;
            cfg_ch.data  <= '0;
            offered_write = '0;
            font_reg  = FONT_SIZE_RESET;
            width_reg = SCREEN_WIDTH_RESET;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                if (offered_write.index == CFG_FONT_SIZE)
                    font_reg = offered_write.data[FS_W-1:0];
                else if (offered_write.index == CFG_SCREEN_WIDTH)
                    width_reg = offered_write.data;
            end
            if (!cfg_ch.valid || cfg_ch.ready)
            begin
                if (pending_writes.size() != 0)
                begin
                    offered_write = pending_writes.pop_front();
                    cfg_ch.valid <= 1'b1;
                    cfg_ch.index <= offered_write.index;
                    cfg_ch.data  <= offered_write.data;
                end
                else
                begin
                    cfg_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Pixel receiver: every accepted word must match the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin : pixel_monitor
        pixel_word_t want;
        if (!rst_n)
        begin
            pix_ch.ready <= 1'b0;
        end
        else
        begin
            if (pix_ch.valid && pix_ch.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    errors++;
                    if (errors <= 50)
                        $display("%0t: unexpected pixel, expected none, actual (%0d,%0d)",
                                 $time, pix_ch.pixel_x, pix_ch.pixel_y);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_x", want.pixel_x, pix_ch.pixel_x);
                    check_field("pixel_y", want.pixel_y, pix_ch.pixel_y);
                    check_field("out_colour", want.out_colour, pix_ch.out_colour);
                    check_field("last_pixel", want.last_pixel, pix_ch.last_pixel);
                end
            end
            pix_ch.ready <= !roll_idle(1'b1);
        end
    end

    task automatic queue_row(input logic ss, input int sx, input int sy, input logic gs,
                             input int cp, input logic [ROW_W-1:0] bits, input int colour);
        row_word_t w;
        w.string_start = ss;
        w.start_x      = COORD_W'(sx);
        w.start_y      = COORD_W'(sy);
        w.glyph_start  = gs;
        w.code_point   = CODE_W'(cp);
        w.row_bits     = bits;
        w.pixel_colour = COLOUR_W'(colour);
        pending_rows.push_back(w);
        items_queued++;
    endtask

    // Waits until every row and write has gone in and every pixel has come
    // out. A row with no set pixel gives nothing to wait for, so a short
    // pause follows to let such a row clear the block.
    task automatic drain();
        while (pending_rows.size() != 0 || row_ch.valid || pending_writes.size() != 0
               || cfg_ch.valid || expected_pixels.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_config(input int fs, input int sw);
        cfg_word_t wr;
        wr.index = CFG_FONT_SIZE;
        wr.data  = CFG_DATA_W'(fs);
        pending_writes.push_back(wr);
        wr.index = CFG_SCREEN_WIDTH;
        wr.data  = CFG_DATA_W'(sw);
        pending_writes.push_back(wr);
        drain();
        gen_fs = (fs > GLYPH_LIMIT) ? GLYPH_LIMIT : fs;
        gen_sw = sw;
    endtask

    // Row patterns: mostly random within the glyph, with empty, full, single
    // column rows and some with junk above the glyph's leftmost column.
    function automatic logic [ROW_W-1:0] pick_row_bits(input int fs);
        logic [ROW_W-1:0] mask;
        mask = (fs >= 32) ? '1 : ((ROW_W'(1) << fs) - 1);
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return mask;
            2:       return ROW_W'(1) << $urandom_range((fs > 0) ? fs - 1 : 0, 0);
            3:       return $urandom;
            default: return $urandom & mask;
        endcase
    endfunction

    // Code points cluster around the half-width boundary at 127.
    function automatic int pick_code_point();
        case ($urandom_range(5, 0))
            0:       return $urandom_range(127, 0);
            1:       return $urandom_range(128, 127);
            2:       return $urandom_range(65535, 128);
            3:       return $urandom_range(65535, 65000);
            default: return $urandom_range(255, 0);
        endcase
    endfunction

    // One text run: a string start followed by a few glyphs of font-size rows
    // each. A broken run may miss its string or glyph markers, cut glyphs
    // short or run rows past the glyph height. The run is cut off once the
    // phase's item budget is spent.
    task automatic queue_text_run(input bit well_formed, input int stop_at);
        int n_glyphs;
        int n_rows;
        int g;
        int r;
        int sx;
        int sy;
        int cp;
        n_glyphs = $urandom_range((gen_fs >= 16) ? 2 : 5, 1);
        case ($urandom_range(4, 0))
            0:       sx = $urandom_range(COORD_TOP, 0);
            1:       sx = gen_sw - $urandom_range(2 * gen_fs + 1, 0);
            2:       sx = 0;
            3:       sx = COORD_TOP - $urandom_range(40, 0);
            default: sx = $urandom_range(gen_sw, 0);
        endcase
        if (sx < 0)
            sx = 0;
        case ($urandom_range(3, 0))
            0:       sy = $urandom_range(COORD_TOP, 0);
            1:       sy = COORD_TOP - $urandom_range(40, 0);
            default: sy = $urandom_range(200, 0);
        endcase
        for (g = 0; g < n_glyphs && items_queued < stop_at; g++)
        begin
            cp = pick_code_point();
            n_rows = (gen_fs == 0) ? 2 : gen_fs;
            if (!well_formed)
                n_rows = $urandom_range(n_rows + 3, 1);
            else if ($urandom_range(9, 0) == 0)
                n_rows += $urandom_range(3, 1);
            for (r = 0; r < n_rows && items_queued < stop_at; r++)
            begin
                queue_row((g == 0 && r == 0) && (well_formed || $urandom_range(1, 0) == 1),
                          (r == 0) ? sx : $urandom_range(COORD_TOP, 0),
                          (r == 0) ? sy : $urandom_range(COORD_TOP, 0),
                          (r == 0) && (well_formed || $urandom_range(3, 0) != 0),
                          cp, pick_row_bits(gen_fs), $urandom_range(65535, 0));
            end
        end
    endtask

    // One random phase: new settings, new idle pattern, then text runs until
    // the item budget is spent. The long tail keeps feeding rows of a single
    // glyph well past 64 rows, where a wrapping row counter would start to
    // draw again.
    task automatic run_phase(input int fs, input int sw, input idle_mode_t mode,
                             input int n_items, input bit long_tail);
        int stop;
        int pick;
        int i;
        write_config(fs, sw);
        idle_mode = mode;
        stop = items_queued + n_items;
        while (items_queued < stop)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 10)
                queue_row($urandom_range(1, 0), $urandom_range(COORD_TOP, 0),
                          $urandom_range(COORD_TOP, 0), $urandom_range(1, 0),
                          $urandom_range(65535, 0), $urandom, $urandom_range(65535, 0));
            else
                queue_text_run(pick >= 20, stop);
        end
        if (long_tail)
        begin
            queue_row(1'b1, 0, 0, 1'b1, 16'h0041, '1, 16'hFFFF);
            for (i = 1; i < 72; i++)
                queue_row(1'b0, 0, 0, 1'b0, 0, '1, i);
        end
        drain();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: 16 pixel glyphs on a 160 pixel line.
        // A row before any glyph start draws at the reset origin, then an empty row.
        queue_row(1'b0, 0, 0, 1'b0, 0, 32'h0000_FFFF, 16'h1234);
        queue_row(1'b0, 0, 0, 1'b0, 0, 32'h0000_0000, 16'h4321);
        queue_row(1'b1, 0, 0, 1'b1, 65, 32'h0000_8001, 16'hFFFF);
        // Junk above the glyph's leftmost column must be ignored.
        queue_row(1'b0, 0, 0, 1'b0, 0, 32'hFFFF_FFFF, 16'h0000);
        // Half-width glyph at 127 just fits; the full-width one at 128 wraps.
        queue_row(1'b1, 150, 10, 1'b1, 127, 32'h0000_0001, 16'hAAAA);
        queue_row(1'b0, 0, 0, 1'b1, 128, 32'h0000_8000, 16'h5555);
        queue_row(1'b0, 0, 0, 1'b1, 16'hFFFF, 32'h0000_5555, 16'h0F0F);
        queue_row(1'b0, 0, 0, 1'b1, 0, 32'h0000_AAAA, 16'hF0F0);
        // Start at the far corner: the wrap pushes the line below 2047, which clips.
        queue_row(1'b1, COORD_TOP, COORD_TOP, 1'b1, 300, 32'h0000_FFFF, 16'h8000);
        queue_row(1'b0, 0, 0, 1'b0, 0, 32'h0000_8000, 16'h0001);
        drain();

        // Tiny glyphs on the widest screen, placed against the far corner.
        write_config(4, COORD_TOP);
        queue_row(1'b1, 2045, 2046, 1'b1, 5, 32'h0000_000F, 16'h0F0F);
        queue_row(1'b0, 0, 0, 1'b0, 0, 32'h0000_00F0, 16'h1111);
        queue_row(1'b0, 0, 0, 1'b0, 0, 32'h0000_0009, 16'h2222);
        queue_row(1'b0, 0, 0, 1'b0, 0, 32'h0000_0006, 16'h3333);
        // Rows five and six lie past the glyph height and draw nothing.
        queue_row(1'b0, 0, 0, 1'b0, 0, 32'h0000_000F, 16'h4444);
        queue_row(1'b0, 0, 0, 1'b0, 0, 32'hFFFF_FFFF, 16'h5555);
        // Cursor already at 2047: this glyph wraps to x 0 and the line clips.
        queue_row(1'b0, 0, 0, 1'b1, 200, 32'h0000_0001, 16'h6666);
        queue_row(1'b1, 0, 0, 1'b1, 1, 32'h0000_0008, 16'h7777);
        drain();

        run_phase(8, 64, IDLE_SENDER, 25, 1'b0);
        run_phase(32, COORD_TOP, IDLE_RECEIVER, 25, 1'b0);
        // A one pixel screen with one pixel glyphs, whose half-width advance is zero.
        run_phase(1, 1, IDLE_BOTH, 25, 1'b0);
        run_phase(16, 1, IDLE_NONE, 20, 1'b0);
        // Font size zero: nothing advances and nothing draws.
        run_phase(0, 100, IDLE_NONE, 15, 1'b0);
        // Oversized font register, clamped to 32.
        run_phase(63, 300, IDLE_RECEIVER, 25, 1'b1);
        run_phase(5, 37, IDLE_SENDER, 20, 1'b0);
        run_phase($urandom_range(32, 1), $urandom_range(COORD_TOP, 1), IDLE_BOTH, 25, 1'b0);

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/gtlpe_pkg.sv
rtl/gtlpe_row_if.sv
rtl/gtlpe_pixel_if.sv
rtl/gtlpe_cfg_if.sv
rtl/gtlpe_layout.sv
rtl/gtlpe_emitter.sv
rtl/glyph_text_layout_pixel_emitter_unit.sv
rtl/gtlpe_checker.sv
verif/glyph_text_layout_pixel_emitter_unit_test.sv
